// ===== rtl/euclidean_lsh_bucket_hash_macros.svh =====
// assertion macros shared by the rtl
`ifndef EUCLIDEAN_LSH_BUCKET_HASH_MACROS_SVH
`define EUCLIDEAN_LSH_BUCKET_HASH_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ELBH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked on every rising clock edge outside reset
`define ELBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/elbh_pkg.sv =====
// shared constants, types and codes of the lsh bucket hash
`default_nettype none
package elbh_pkg;
    localparam int TABLES = 5;
    localparam int HASHES = 4;
    localparam int DIMS   = 128;
    localparam int PAIRS  = TABLES * HASHES;
    localparam int PW     = $clog2(PAIRS);
    localparam int DW     = $clog2(DIMS);
    localparam int CW     = $clog2(DIMS + 1);
    localparam int HW     = (HASHES > 1) ? $clog2(HASHES) : 1;
    localparam int KW     = $clog2(HASHES + 1);
    localparam int LW     = $clog2(TABLES + 1);
    localparam int MW     = $clog2(PAIRS * DIMS);
    localparam logic [52:0] PRIME = 53'h0F_FFFF_FFFF_FFFB;

    typedef enum logic [2:0] {
        FN_COEFF = 3'd0,
        FN_OFFSET = 3'd1,
        FN_MULT = 3'd2,
        FN_SHUF = 3'd3,
        FN_COORD = 3'd4
    } t_func;

    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAC, ST_HASH, ST_HDIV, ST_COMB, ST_MODP, ST_MODB, ST_EMIT, ST_CLR
    } t_state;

    typedef struct packed {
        logic mac_init;   // load x, zero pair counter
        logic mac_step;   // one multiply-accumulate
        logic hash_init;  // start a table: zero k
        logic div_start;
        logic comb_step;
        logic modp_start;
        logic modb_start;
        logic emit;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic mac_done;
        logic div_done;
        logic hashes_done;
        logic comb_done;
        logic modp_done;
        logic modb_done;
        logic tables_done;
        logic clr_done;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/euclidean_lsh_bucket_hash.sv =====
// top level of the lsh bucket hash
// A coordinate keeps busy high while one shared multiplier works through the pairs, one pair
// a cycle, fed by registered reads, so the next coordinate is taken only after busy falls.
// A last coordinate then runs a serial divide per hash and, per table, combines, reduces
// modulo the prime and the bucket count and strobes the result, then clears every accumulator.
// Configuration writes are taken only while busy is low.
// Results appear one per table on o_valid strobes and cannot be stalled.
`default_nettype none
module euclidean_lsh_bucket_hash import elbh_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire         [2:0]  i_func,
    input  wire         [2:0]  i_table_sel,
    input  wire         [2:0]  i_hash_sel,
    input  wire         [7:0]  i_dim_sel,
    input  wire signed  [22:0] i_value,
    input  wire                i_last,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire                i_cfg_index,
    input  wire         [16:0] i_cfg_data,
    output logic               o_valid,
    output logic        [2:0]  o_table_index,
    output logic        [15:0] o_bucket,
    output logic               o_last_bucket
);
    `include "euclidean_lsh_bucket_hash_macros.svh"
    logic [15:0] r_width;
    logic [16:0] r_count;
    t_cmd  cmd;
    t_stat stat;
    logic  acc_en;
    wire   take = start && !busy;

    assign o_cfg_ready = !busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 16'd350;
            r_count <= 17'd1024;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_WIDTH) r_width <= i_cfg_data[15:0];
            if (i_cfg_index == CFG_COUNT) r_count <= i_cfg_data;
        end
    end

    elbh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_go_coord(take && i_func == FN_COORD), .i_last(i_last),
        .i_acc_en(acc_en), .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    elbh_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(take), .i_func(i_func),
        .i_table_sel(i_table_sel), .i_hash_sel(i_hash_sel), .i_dim_sel(i_dim_sel),
        .i_value(i_value), .i_width(r_width), .i_count(r_count), .i_cmd(cmd),
        .o_stat(stat), .o_acc_en(acc_en), .o_valid(o_valid),
        .o_table_index(o_table_index), .o_bucket(o_bucket),
        .o_last_bucket(o_last_bucket)
    );

    `ELBH_ASSERT_IMP(a_no_valid_idle, i_clk, i_rst_n, !busy, !o_valid)
    `ELBH_ASSERT_IMP(a_last_on_final, i_clk, i_rst_n, o_valid && o_last_bucket,
        o_table_index == 3'(TABLES - 1))
    `ELBH_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, cmd.emit, o_valid)
endmodule
`default_nettype wire

// ===== rtl/elbh_ctrl.sv =====
// control state machine of the lsh bucket hash
`default_nettype none
module elbh_ctrl import elbh_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_go_coord,
    input  wire   i_last,
    input  wire   i_acc_en,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);
    t_state r_state, n_state;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        o_busy  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_go_coord) begin
                    n_last = i_last;
                    o_cmd.mac_init = 1'b1;
                    if (i_acc_en) n_state = ST_MAC;
                    else if (i_last) n_state = ST_HASH;
                end
            end
            ST_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_stat.mac_done) n_state = r_last ? ST_HASH : ST_IDLE;
            end
            ST_HASH: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_HDIV;
            end
            ST_HDIV: begin
                if (i_stat.div_done) n_state = i_stat.hashes_done ? ST_COMB : ST_HASH;
            end
            ST_COMB: begin
                o_cmd.comb_step = 1'b1;
                if (i_stat.comb_done) begin
                    o_cmd.modp_start = 1'b1;
                    n_state = ST_MODP;
                end
            end
            ST_MODP: begin
                if (i_stat.modp_done) begin
                    o_cmd.modb_start = 1'b1;
                    n_state = ST_MODB;
                end
            end
            ST_MODB: begin
                if (i_stat.modb_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.tables_done) n_state = ST_CLR;
                else begin
                    o_cmd.hash_init = 1'b1;
                    n_state = ST_HASH;
                end
            end
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/elbh_datapath.sv =====
// stores, shared multiplier, dividers and modular reduction
`default_nettype none
module elbh_datapath import elbh_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_wr,
    input  wire         [2:0]  i_func,
    input  wire         [2:0]  i_table_sel,
    input  wire         [2:0]  i_hash_sel,
    input  wire         [7:0]  i_dim_sel,
    input  wire signed  [22:0] i_value,
    input  wire         [15:0] i_width,
    input  wire         [16:0] i_count,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic               o_acc_en,
    output logic               o_valid,
    output logic        [2:0]  o_table_index,
    output logic        [15:0] o_bucket,
    output logic               o_last_bucket
);
    logic [15:0] r_coef [PAIRS*DIMS];
    logic [21:0] r_offs [PAIRS];
    logic [5:0]  r_mult [PAIRS];
    logic [2:0]  r_shuf [PAIRS];
    logic signed [47:0] r_acc [PAIRS];
    logic [CW-1:0] r_cidx;

    wire sel_ok = (32'(i_table_sel) < TABLES) && (32'(i_hash_sel) < HASHES);
    wire [PW-1:0] wpair = PW'(32'(i_table_sel) * HASHES + 32'(i_hash_sel));
    assign o_acc_en = (32'(r_cidx) < DIMS);

    // coefficient memory, one read port
    logic [PW-1:0] r_p;
    logic [15:0]   r_crd;
    logic          r_cv;
    logic signed [22:0] r_x;
    wire [MW-1:0] raddr = MW'(32'(r_p) * DIMS + 32'(r_cidx[DW-1:0]));
    always_ff @(posedge i_clk) begin
        if (i_wr && i_func == FN_COEFF && sel_ok && 32'(i_dim_sel) < DIMS)
            r_coef[MW'(32'(wpair) * DIMS + 32'(i_dim_sel))] <= i_value[15:0];
        r_crd <= r_coef[raddr];
    end
    always_ff @(posedge i_clk) begin
        if (i_wr && sel_ok) begin
            if (i_func == FN_OFFSET) r_offs[wpair] <= i_value[21:0];
            if (i_func == FN_MULT)   r_mult[wpair] <= i_value[5:0];
            if (i_func == FN_SHUF)   r_shuf[wpair] <= i_value[2:0];
        end
    end

    // mac: issue read of pair p, next cycle multiply-add
    logic signed [38:0] prod;
    assign prod = r_x * $signed(r_crd);
    logic [PW-1:0] r_pm;
    wire mac_last_issue = (32'(r_p) == PAIRS - 1);
    assign o_stat.mac_done = r_cv && (32'(r_pm) == PAIRS - 1);

    // hash computation state
    logic [LW-1:0] r_l;
    logic [KW-1:0] r_k;
    logic signed [35:0] r_h [HASHES];
    wire [PW-1:0] hpair = PW'(32'(r_l) * HASHES + 32'(r_k));
    assign o_stat.hashes_done = (32'(r_k) == HASHES - 1);
    assign o_stat.tables_done = (32'(r_l) == TABLES - 1);

    // restoring divider: |dividend| < 2^48, divisor = w*2^13
    logic [47:0] r_rem, r_quo;
    logic [5:0]  r_dcnt;
    logic        r_dbusy, r_dneg, r_ddone;
    wire [15:0] wv = (i_width == 16'd0) ? 16'd1 : i_width;
    wire [28:0] dvs = {wv, 13'd0};
    wire signed [48:0] sum = 49'(r_acc[hpair]) + 49'(r_offs[hpair]);
    wire [48:0] mag = sum[48] ? 49'(-sum) : 49'(sum);
    wire [48:0] trial = {r_rem[47:0], r_quo[47]};
    wire        fits = trial >= 49'(dvs);
    assign o_stat.div_done = r_ddone;

    // combine
    logic [KW-1:0] r_ci;
    logic signed [43:0] r_rh;
    wire [PW-1:0] cpair = PW'(32'(r_l) * HASHES + 32'(r_ci));
    wire [HW-1:0] sidx = HW'(32'(r_shuf[cpair]) % HASHES);
    wire signed [41:0] cterm = r_h[sidx] * $signed(r_mult[cpair]);
    assign o_stat.comb_done = (32'(r_ci) == HASHES - 1);

    // mod prime: rh magnitude < 2^44 < prime, so only sign fix
    // taken from the registered start r_mpgo so that the last combine term has landed
    logic [52:0] r_res;
    logic        r_mpgo, r_mpd;
    assign o_stat.modp_done = r_mpd;

    // mod bucket count by restoring division over 53 bits
    wire [16:0] bc = (i_count == 17'd0) ? 17'd1 : (i_count[16] ? 17'h10000 : i_count);
    logic [52:0] r_bq;
    logic [17:0] r_br;
    logic [5:0]  r_bcnt;
    logic        r_bbusy, r_bdone;
    wire [17:0] btrial = {r_br[16:0], r_bq[52]};
    wire        bfits = btrial >= 18'(bc);
    assign o_stat.modb_done = r_bdone;

    logic [PW-1:0] r_clr;
    assign o_stat.clr_done = (32'(r_clr) == PAIRS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cidx <= '0; r_cv <= 1'b0; r_p <= '0; r_l <= '0; r_k <= '0; r_ci <= '0;
            r_dbusy <= 1'b0; r_ddone <= 1'b0; r_mpd <= 1'b0; r_bbusy <= 1'b0;
            r_bdone <= 1'b0; o_valid <= 1'b0; r_clr <= '0; r_mpgo <= 1'b0;
            for (int i = 0; i < PAIRS; i++) r_acc[i] <= '0;
        end else begin
            o_valid <= 1'b0;
            r_ddone <= 1'b0;
            r_mpgo  <= 1'b0;
            r_mpd   <= 1'b0;
            r_bdone <= 1'b0;
            r_cv    <= 1'b0;
            if (i_cmd.mac_init) begin
                r_x <= i_value;
                r_p <= '0;
                r_l <= '0;
                r_k <= '0;
            end
            if (i_cmd.mac_step) begin
                if (!mac_last_issue) r_p <= r_p + 1'b1;
                r_cv <= !o_stat.mac_done;
                r_pm <= r_p;
                if (r_cv) r_acc[r_pm] <= r_acc[r_pm] + 48'(prod);
                if (o_stat.mac_done) begin
                    r_cidx <= r_cidx + 1'b1;
                    r_p <= '0;
                    r_cv <= 1'b0;
                end
            end
            if (i_cmd.div_start) begin
                r_rem <= '0;
                r_quo <= mag[47:0];
                r_dneg <= sum[48];
                r_dcnt <= '0;
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                r_rem <= fits ? 48'(trial - 49'(dvs)) : trial[47:0];
                r_quo <= {r_quo[46:0], fits};
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == 6'd47) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
            if (r_ddone) begin
                r_h[r_k[HW-1:0]] <= r_dneg ? -$signed(r_quo[35:0]) : $signed(r_quo[35:0]);
                if (!o_stat.hashes_done) r_k <= r_k + 1'b1;
                else begin
                    r_ci <= '0;
                    r_rh <= '0;
                end
            end
            if (i_cmd.comb_step) begin
                r_rh <= r_rh + 44'(cterm);
                r_ci <= r_ci + 1'b1;
            end
            if (i_cmd.modp_start) r_mpgo <= 1'b1;
            if (r_mpgo) begin
                r_res <= r_rh[43] ? 53'(PRIME + 53'($signed(r_rh))) : 53'(r_rh);
                r_mpd <= 1'b1;
            end
            if (i_cmd.modb_start) begin
                r_bq <= r_res;
                r_br <= '0;
                r_bcnt <= '0;
                r_bbusy <= 1'b1;
            end else if (r_bbusy) begin
                r_br <= bfits ? btrial - 18'(bc) : btrial;
                r_bq <= {r_bq[51:0], 1'b0};
                r_bcnt <= r_bcnt + 1'b1;
                if (r_bcnt == 6'd52) begin
                    r_bbusy <= 1'b0;
                    r_bdone <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                o_valid <= 1'b1;
                o_table_index <= 3'(r_l);
                o_bucket <= r_br[15:0];
                o_last_bucket <= o_stat.tables_done;
                r_clr <= '0;
            end
            if (i_cmd.hash_init) begin
                r_l <= r_l + 1'b1;
                r_k <= '0;
            end
            if (i_cmd.clr_step) begin
                r_acc[r_clr] <= '0;
                r_clr <= r_clr + 1'b1;
                if (o_stat.clr_done) r_cidx <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_euclidean_lsh_bucket_hash.sv =====
// testbench for the lsh bucket hash: directed and random beats checked by a predictor
module tb_euclidean_lsh_bucket_hash;
    import elbh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 20000;
    localparam int LOAD_DIMS    = 2;
    localparam int RANDOM_ITEMS = 30;

    typedef struct packed {
        logic [2:0]  tbl;
        logic [15:0] bkt;
        logic        lastb;
    } t_bucket;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_func = '0;
    logic [2:0] i_table_sel = '0;
    logic [2:0] i_hash_sel = '0;
    logic [7:0] i_dim_sel = '0;
    logic signed [22:0] i_value = '0;
    logic i_last = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [16:0] i_cfg_data = '0;
    logic o_valid;
    logic [2:0] o_table_index;
    logic [15:0] o_bucket;
    logic o_last_bucket;

    euclidean_lsh_bucket_hash DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] coeff_mem [PAIRS*DIMS];
    logic [21:0] offset_mem [PAIRS];
    logic [5:0]  mult_mem [PAIRS];
    logic [2:0]  shuf_mem [PAIRS];
    longint      dot_sum [PAIRS];
    int          coords_taken;
    logic [15:0] width_reg;
    logic [16:0] count_reg;

    t_bucket bucket_q[$];
    int  fail_cnt = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;

    function automatic longint sdiv_trunc(longint a, longint b);
        longint q;
        q = (a < 0 ? -a : a) / b;
        return (a < 0) ? -q : q;
    endfunction

    task automatic predict_item(logic [2:0] fn, logic [2:0] ts, logic [2:0] hs,
                                logic [7:0] ds, logic [22:0] v, logic lst);
        int pr;
        longint w, bc, rh, res, hv[HASHES];
        t_bucket nb;
        pr = ts * HASHES + hs;
        if (fn == FN_COORD) begin
            if (coords_taken < DIMS) begin
                for (int p = 0; p < PAIRS; p++)
                    dot_sum[p] += longint'($signed(v)) *
                                  longint'($signed(coeff_mem[p*DIMS + coords_taken]));
                coords_taken++;
            end
            if (lst) begin
                w = (width_reg == 0) ? 1 : width_reg;
                bc = (count_reg == 0) ? 1 : (count_reg > 65536 ? 65536 : count_reg);
                for (int l = 0; l < TABLES; l++) begin
                    for (int k = 0; k < HASHES; k++)
                        hv[k] = sdiv_trunc(dot_sum[l*HASHES+k] +
                                           longint'(offset_mem[l*HASHES+k]), w * 8192);
                    rh = 0;
                    for (int k = 0; k < HASHES; k++)
                        rh += hv[shuf_mem[l*HASHES+k] % HASHES] *
                              longint'($signed(mult_mem[l*HASHES+k]));
                    res = rh % 64'sd4503599627370491;
                    if (res < 0) res += 64'sd4503599627370491;
                    nb = '{3'(l), 16'(res % bc), l == TABLES - 1};
                    bucket_q = {bucket_q, nb};
                end
                for (int p = 0; p < PAIRS; p++) dot_sum[p] = 0;
                coords_taken = 0;
            end
        end else if (ts < TABLES && hs < HASHES) begin
            case (fn)
                FN_COEFF: if (ds < DIMS) coeff_mem[pr*DIMS + ds] = v[15:0];
                FN_OFFSET: offset_mem[pr] = v[21:0];
                FN_MULT: mult_mem[pr] = v[5:0];
                FN_SHUF: shuf_mem[pr] = v[2:0];
                default: ;
            endcase
        end
    endtask

    task automatic gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    // start stays high into the next beat unless a gap or a drain lowers it
    task automatic send_beat(logic [2:0] fn, logic [2:0] ts, logic [2:0] hs,
                             logic [7:0] ds, logic [22:0] v, logic lst);
        gap();
        i_func <= fn; i_table_sel <= ts; i_hash_sel <= hs;
        i_dim_sel <= ds; i_value <= v; i_last <= lst; start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_item(fn, ts, hs, ds, v, lst);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (bucket_q.size() != 0) @(negedge i_clk);
        repeat (1200) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] d);
        i_cfg_index <= idx; i_cfg_data <= d; i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_WIDTH) width_reg = d[15:0]; else count_reg = d;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // fill the stores that points read: every pair, the leading coordinates only
    task automatic load_tables(bit extreme);
        logic [22:0] v;
        for (int p = 0; p < PAIRS; p++) begin
            for (int d = 0; d < LOAD_DIMS; d++) begin
                v = extreme ? ((p + d) % 2 ? 23'h7F_7FFF : 23'h00_8000) : 23'($urandom);
                send_beat(FN_COEFF, 3'(p / HASHES), 3'(p % HASHES), 8'(d), v, 1'($urandom));
            end
            v = extreme ? (p % 2 ? 23'h3F_FFFF : 23'h40_0000) : 23'($urandom);
            send_beat(FN_OFFSET, 3'(p / HASHES), 3'(p % HASHES), 8'($urandom), v, 1'b0);
            v = extreme ? (p % 2 ? 23'h00_001F : 23'h7F_FFE0) : 23'($urandom);
            send_beat(FN_MULT, 3'(p / HASHES), 3'(p % HASHES), 8'($urandom), v, 1'b1);
            send_beat(FN_SHUF, 3'(p / HASHES), 3'(p % HASHES), 8'($urandom),
                      23'($urandom), 1'b0);
        end
    endtask

    task automatic send_point(int n, bit extreme);
        logic [22:0] v;
        for (int i = 0; i < n; i++) begin
            v = extreme ? (i % 2 ? 23'h3F_FFFF : 23'h40_0000) : 23'($urandom);
            send_beat(FN_COORD, 3'($urandom), 3'($urandom), 8'($urandom), v, i == n - 1);
        end
    endtask

    task automatic test_directed();
        idle_on = 1'b0;
        load_tables(1'b1);
        idle_on = 1'b1;
        send_point(LOAD_DIMS, 1'b1);
        send_point(1, 1'b0);
        // writes outside the tables and unused func codes
        send_beat(FN_COEFF, 3'd7, 3'd0, 8'd0, 23'h12345, 1'b0);
        send_beat(FN_OFFSET, 3'd0, 3'd7, 8'd0, 23'h12345, 1'b0);
        send_beat(FN_COEFF, 3'd0, 3'd0, 8'd255, 23'h12345, 1'b0);
        send_beat(3'd5, 3'd0, 3'd0, 8'd0, 23'h0, 1'b1);
        send_beat(3'd6, 3'd1, 3'd1, 8'd1, 23'h7FFFFF, 1'b1);
        send_beat(3'd7, 3'd2, 3'd2, 8'd2, 23'h400000, 1'b1);
        send_point(LOAD_DIMS, 1'b0);
        drain();
    endtask

    task automatic test_config();
        logic [16:0] wv[4] = '{17'd0, 17'd1, 17'd65535, 17'd3};
        logic [16:0] cv[4] = '{17'd0, 17'd1, 17'd131071, 17'd65536};
        for (int i = 0; i < 4; i++) begin
            write_reg(CFG_WIDTH, wv[i]);
            write_reg(CFG_COUNT, cv[i]);
            send_point(LOAD_DIMS, 1'b1);
            send_point($urandom_range(1, LOAD_DIMS), 1'b0);
            drain();
        end
        write_reg(CFG_WIDTH, 17'd1);
        write_reg(CFG_COUNT, 17'd997);
    endtask

    task automatic test_random();
        int sel;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 6) idle_on = 1'b0;
            sel = $urandom_range(0, 9);
            if (sel < 6)
                send_point($urandom_range(1, LOAD_DIMS), 1'b0);
            else if (sel < 8)
                send_beat(3'($urandom_range(0, 3)), 3'($urandom), 3'($urandom),
                          8'($urandom), 23'($urandom), 1'($urandom));
            else
                send_beat(3'($urandom_range(5, 7)), 3'($urandom), 3'($urandom),
                          8'($urandom), 23'($urandom), 1'($urandom));
        end
        drain();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_bucket exp_b;
        if (i_rst_n && o_valid) begin
            if (bucket_q.size() == 0) begin
                $error("unexpected bucket beat table %0d bucket %0d", o_table_index, o_bucket);
                fail_cnt++;
            end else begin
                exp_b = bucket_q.pop_front();
                if (o_table_index !== exp_b.tbl) begin
                    $error("table_index exp %0d got %0d", exp_b.tbl, o_table_index);
                    fail_cnt++;
                end
                if (o_bucket !== exp_b.bkt) begin
                    $error("bucket exp %0d got %0d", exp_b.bkt, o_bucket);
                    fail_cnt++;
                end
                if (o_last_bucket !== exp_b.lastb) begin
                    $error("last_bucket exp %0d got %0d", exp_b.lastb, o_last_bucket);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat, config write or result
    always @(posedge i_clk) begin
        if (o_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        width_reg = 16'd350;
        count_reg = 17'd1024;
        coords_taken = 0;
        for (int p = 0; p < PAIRS; p++) begin
            dot_sum[p] = 0; offset_mem[p] = '0; mult_mem[p] = '0; shuf_mem[p] = '0;
        end
        for (int m = 0; m < PAIRS*DIMS; m++) coeff_mem[m] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config();
        test_random();
        if (fail_cnt == 0 && bucket_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
